### sv/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

   localparam int MAX_FIND    = 8;
   localparam int MAX_REPLACE = 8;
   localparam int EMIT_DEPTH  = (MAX_FIND > MAX_REPLACE) ? MAX_FIND : MAX_REPLACE;
   localparam int REG_BYTES   = 8;
   localparam int CFG_W       = 64;
   localparam int LEN_FIELD_W = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int FL_W        = $clog2(MAX_FIND + 1);
   localparam int RL_W        = $clog2(MAX_REPLACE + 1);
   localparam int EC_W        = $clog2(EMIT_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIND_PATTERN    = 2'd0,
      CSR_FIND_LENGTH     = 2'd1,
      CSR_REPLACE_PATTERN = 2'd2,
      CSR_REPLACE_LENGTH  = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic take;
      logic shift;
      logic here;
   } win_ctl_type;

   typedef struct packed {
      logic load;
      logic pop;
   } emit_ctl_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_text;
   } emit_ent_type;

   function automatic logic [FL_W-1:0] clamp_find(input logic [LEN_FIELD_W-1:0] v);
      logic [FL_W-1:0] r;
      if (v == '0) begin
         r = FL_W'(1);
      end else if (int'(v) > MAX_FIND) begin
         r = FL_W'(MAX_FIND);
      end else begin
         r = FL_W'(v);
      end
      return r;
   endfunction

   function automatic logic [RL_W-1:0] clamp_replace(input logic [LEN_FIELD_W-1:0] v);
      logic [RL_W-1:0] r;
      if (int'(v) > MAX_REPLACE) begin
         r = RL_W'(MAX_REPLACE);
      end else begin
         r = RL_W'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/sfr_if.sv
`default_nettype none

interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_byte;
   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface sfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       end_of_text;
   modport source (output valid, output out_byte, output byte_valid, output end_of_text,
                   input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input end_of_text,
                   output ready);
endinterface

interface sfr_csr_if import sfr_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/streaming_find_replace.sv
// Streaming find-and-replace-all over a byte stream.
// req_chan carries one source byte per request with last_byte marking the end
// of a text. rsp_chan carries rewritten bytes; byte_valid is low only on the
// empty end marker, and end_of_text flags the final result of each text.
// csr_chan writes find_pattern, find_length, replace_pattern, replace_length
// (index 0 to 3); csr_ready is always high. Write it only while idle.
// Results of a request appear on rsp_chan from the cycle after it is taken, one
// per cycle with rsp_ready high, from an 8-entry output shift chain. A request
// that yields k results keeps the output busy until all are taken; the next
// request is taken in the same cycle the last pending result is taken, so plain
// text streams at one byte per cycle with rsp_ready high, and a replacement
// stalls the input until its last result is taken. A request that yields
// nothing (window still filling) is taken at once whenever the output is empty.
// Reset empties the window and the output chain and restores the registers to
// find_length 1 and everything else zero. When rsp_ready is low the head
// result holds and requests stall while any result is pending.
`default_nettype none

module streaming_find_replace import sfr_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   sfr_req_if.sink   req_chan,
   sfr_rsp_if.source rsp_chan,
   sfr_csr_if.sink   csr_chan
);

   logic [CFG_W-1:0] find_ff, find_in;
   logic [FL_W-1:0]  flen_ff, flen_in;
   logic [CFG_W-1:0] rep_ff, rep_in;
   logic [RL_W-1:0]  rlen_ff, rlen_in;
   logic [FL_W-1:0]  fill_ff, fill_in;
   logic [EC_W-1:0]  ecnt_ff, ecnt_in;

   logic             req_acc;
   logic             rsp_pop;
   logic             csr_acc;
   logic             flen_wr;
   logic             full;
   logic             match;
   logic             last;
   logic             marker;
   logic [EC_W-1:0]  n_raw;
   logic [EC_W-1:0]  n_fin;

   logic [7:0]       cand [MAX_FIND];
   logic [MAX_FIND-1:0] eq_vec;
   win_ctl_type      win_ctl [MAX_FIND];
   emit_ctl_type     emit_ctl;
   emit_ent_type     ld [EMIT_DEPTH];
   emit_ent_type     ent [EMIT_DEPTH];

   assign csr_chan.ready = 1'b1;
   assign csr_acc        = csr_chan.valid && csr_chan.ready;
   assign flen_wr        = csr_acc && (csr_idx_type'(csr_chan.index) == CSR_FIND_LENGTH);

   assign req_chan.ready = (ecnt_ff == '0) || ((ecnt_ff == EC_W'(1)) && rsp_chan.ready);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign rsp_pop        = rsp_chan.valid && rsp_chan.ready;
   assign last           = req_chan.last_byte;

   assign full  = (fill_ff + FL_W'(1)) == flen_ff;
   assign match = full && (&eq_vec);

   always_comb begin
      if (match) begin
         n_raw = EC_W'(rlen_ff);
      end else if (last) begin
         n_raw = EC_W'(fill_ff) + EC_W'(1);
      end else if (full) begin
         n_raw = EC_W'(1);
      end else begin
         n_raw = '0;
      end
   end

   assign marker = last && (n_raw == '0);
   assign n_fin  = marker ? EC_W'(1) : n_raw;

   genvar i;
   generate
      for (i = 0; i < MAX_FIND; i++) begin : g_win
         logic [7:0] nbr;
         logic [7:0] pat;

         if (i < MAX_FIND - 1) begin : g_nbr
            assign nbr = cand[i+1];
         end else begin : g_end
            assign nbr = 8'h00;
         end

         if (i < REG_BYTES) begin : g_pat
            assign pat = find_ff[8*i +: 8];
         end else begin : g_zero
            assign pat = 8'h00;
         end

         assign win_ctl[i].take  = req_acc;
         assign win_ctl[i].shift = full;
         assign win_ctl[i].here  = (fill_ff == FL_W'(i));

         sfr_win_cell u_cell (
            .clock    (clock),
            .ctl      (win_ctl[i]),
            .in_byte  (req_chan.in_byte),
            .nbr_cand (nbr),
            .pat_byte (pat),
            .in_use   (FL_W'(i) < flen_ff),
            .cand     (cand[i]),
            .eq_ok    (eq_vec[i])
         );
      end
   endgenerate

   assign emit_ctl.load = req_acc;
   assign emit_ctl.pop  = rsp_pop;

   generate
      for (i = 0; i < EMIT_DEPTH; i++) begin : g_emit
         logic [7:0]   rep_b;
         logic [7:0]   win_b;
         emit_ent_type nbr;

         if ((i < MAX_REPLACE) && (i < REG_BYTES)) begin : g_rep
            assign rep_b = rep_ff[8*i +: 8];
         end else begin : g_rep_zero
            assign rep_b = 8'h00;
         end

         if (i < MAX_FIND) begin : g_wb
            assign win_b = cand[i];
         end else begin : g_wb_zero
            assign win_b = 8'h00;
         end

         if (i < EMIT_DEPTH - 1) begin : g_nbr
            assign nbr = ent[i+1];
         end else begin : g_end
            assign nbr = '0;
         end

         assign ld[i].out_byte    = marker ? 8'h00 : (match ? rep_b : win_b);
         assign ld[i].byte_valid  = !marker;
         assign ld[i].end_of_text = last && (n_fin == EC_W'(i + 1));

         sfr_emit_cell u_cell (
            .clock (clock),
            .ctl   (emit_ctl),
            .ld    (ld[i]),
            .nbr   (nbr),
            .ent   (ent[i])
         );
      end
   endgenerate

   assign rsp_chan.valid       = (ecnt_ff != '0);
   assign rsp_chan.out_byte    = ent[0].out_byte;
   assign rsp_chan.byte_valid  = ent[0].byte_valid;
   assign rsp_chan.end_of_text = ent[0].end_of_text;

   always_comb begin
      find_in = find_ff;
      flen_in = flen_ff;
      rep_in  = rep_ff;
      rlen_in = rlen_ff;
      if (csr_acc) begin
         unique case (csr_idx_type'(csr_chan.index))
            CSR_FIND_PATTERN:    find_in = csr_chan.data;
            CSR_FIND_LENGTH:     flen_in = clamp_find(csr_chan.data[LEN_FIELD_W-1:0]);
            CSR_REPLACE_PATTERN: rep_in  = csr_chan.data;
            CSR_REPLACE_LENGTH:  rlen_in = clamp_replace(csr_chan.data[LEN_FIELD_W-1:0]);
            default:             find_in = find_ff;
         endcase
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (flen_wr) begin
         fill_in = '0;
      end else if (req_acc) begin
         if (match || last) begin
            fill_in = '0;
         end else if (!full) begin
            fill_in = fill_ff + FL_W'(1);
         end
      end
   end

   always_comb begin
      ecnt_in = ecnt_ff;
      if (req_acc) begin
         ecnt_in = n_fin;
      end else if (rsp_pop) begin
         ecnt_in = ecnt_ff - EC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         find_ff <= '0;
         flen_ff <= FL_W'(1);
         rep_ff  <= '0;
         rlen_ff <= '0;
         fill_ff <= '0;
         ecnt_ff <= '0;
      end else begin
         find_ff <= find_in;
         flen_ff <= flen_in;
         rep_ff  <= rep_in;
         rlen_ff <= rlen_in;
         fill_ff <= fill_in;
         ecnt_ff <= ecnt_in;
      end
   end

   a_accept_drained: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> ((ecnt_ff == '0) || ((ecnt_ff == EC_W'(1)) && rsp_pop)))
      else $error("request taken while results still pending");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff < flen_ff)
      else $error("window fill reached find length");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (req_acc && last) |=> (fill_ff == '0))
      else $error("window not cleared after final byte");

   a_end_is_tail: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.end_of_text) |-> (ecnt_ff == EC_W'(1)))
      else $error("end of text flagged before the final result");

endmodule

`default_nettype wire

### sv/sfr_win_cell.sv
`default_nettype none

module sfr_win_cell import sfr_pkg::*; (
   input  wire logic        clock,
   input  wire win_ctl_type ctl,
   input  wire logic [7:0]  in_byte,
   input  wire logic [7:0]  nbr_cand,
   input  wire logic [7:0]  pat_byte,
   input  wire logic        in_use,
   output logic [7:0]       cand,
   output logic             eq_ok
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   assign cand  = ctl.here ? in_byte : byte_ff;
   assign eq_ok = !in_use || (cand == pat_byte);

   always_comb begin
      byte_in = byte_ff;
      if (ctl.take) begin
         byte_in = ctl.shift ? nbr_cand : cand;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

`default_nettype wire

### sv/sfr_emit_cell.sv
`default_nettype none

module sfr_emit_cell import sfr_pkg::*; (
   input  wire logic         clock,
   input  wire emit_ctl_type ctl,
   input  wire emit_ent_type ld,
   input  wire emit_ent_type nbr,
   output emit_ent_type      ent
);

   emit_ent_type ent_ff;
   emit_ent_type ent_in;

   always_comb begin
      ent_in = ent_ff;
      if (ctl.load) begin
         ent_in = ld;
      end else if (ctl.pop) begin
         ent_in = nbr;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign ent = ent_ff;

endmodule

`default_nettype wire
